// ----- rtl/bpfa_pkg.sv -----
// Shared constants, types and bit-vector helpers of the bitmap page frame allocator.
`default_nettype none

package bpfa_pkg;

  localparam int MAX_PAGES_DEF = 65536;
  localparam int WORD_BITS_DEF = 64;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

  // Per-word changed-bit count, up to 64.
  localparam int N_W = 7;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_LOCK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd4;

  localparam int IN_W  = 40;
  localparam int OUT_W = 72;

  typedef struct packed {
    logic                 init;
    logic [CNT_W-1:0]     init_free;
    logic                 apply;
    logic [CMD_W-1:0]     cmd;
    logic [N_W-1:0]       n;
  } cnt_op_t;

  // Population count as a six-level adder tree.
  function automatic logic [N_W-1:0] popcnt64(input logic [63:0] v);
    logic [N_W-1:0] s [64];
    for (int i = 0; i < 64; i++) begin
      s[i] = N_W'(v[i]);
    end
    for (int lvl = 0; lvl < 6; lvl++) begin
      for (int i = 0; i < (64 >> (lvl + 1)); i++) begin
        s[i] = s[2*i] + s[2*i+1];
      end
    end
    return s[0];
  endfunction

  // Index of the single set bit of a one-hot word.
  function automatic logic [5:0] enc64(input logic [63:0] oh);
    logic [5:0] idx;
    idx = '0;
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 64; i++) begin
        if (((i >> k) & 1) == 1) begin
          idx[k] = idx[k] | oh[i];
        end
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bpfa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bpfa_word_op.sv -----
// Modifies one bitmap word for a run or a first-free search and counts the changed bits.
`default_nettype none

module bpfa_word_op
  import bpfa_pkg::*;
#(
  parameter int WB = WORD_BITS_DEF,
  parameter int LW = $clog2(WB)
) (
  input  wire logic [WB-1:0]  word,
  input  wire logic [LW-1:0]  lo,
  input  wire logic [LW-1:0]  hi,
  input  wire logic           set,
  input  wire logic           find,
  output logic      [WB-1:0]  new_word,
  output logic      [N_W-1:0] n,
  output logic                hit,
  output logic      [LW-1:0]  hit_idx
);

  logic [WB-1:0] ones;
  logic [WB-1:0] mask;
  logic [WB-1:0] cand;
  logic [WB-1:0] lowest;
  logic [WB-1:0] chg;
  logic [5:0]    idx6;

  assign ones   = '1;
  // Bits lo..hi of this word lie inside the run.
  assign mask   = (ones << lo) & (ones >> (LW'(WB - 1) - hi));
  assign cand   = ~word & mask;
  assign lowest = cand & (~cand + WB'(1));
  assign idx6   = enc64(64'(lowest));

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    if (find) begin
      hit      = |cand;
      hit_idx  = idx6[LW-1:0];
      chg      = lowest;
      new_word = word | lowest;
    end else if (set) begin
      chg      = mask & ~word;
      new_word = word | mask;
    end else begin
      chg      = mask & word;
      new_word = word & ~mask;
    end
    n = popcnt64(64'(chg));
  end

endmodule

`default_nettype wire

// ----- rtl/bpfa_counters.sv -----
// Saturating free, used and reserved page counters.
`default_nettype none

module bpfa_counters
  import bpfa_pkg::*;
#(
  parameter logic [CNT_W-1:0] RESET_FREE = TOTAL_RESET
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cnt_op_t          op,
  output logic      [CNT_W-1:0] free_pages,
  output logic      [CNT_W-1:0] used_pages,
  output logic      [CNT_W-1:0] reserved_pages
);

  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] rsv_r, rsv_nxt;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [N_W-1:0] d);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W + 1)'(d);
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] c,
                                               input logic [N_W-1:0] d);
    logic [CNT_W-1:0] dd;
    dd = CNT_W'(d);
    return (c < dd) ? '0 : c - dd;
  endfunction

  always_comb begin
    free_nxt = free_r;
    used_nxt = used_r;
    rsv_nxt  = rsv_r;
    if (op.init) begin
      free_nxt = op.init_free;
      used_nxt = '0;
      rsv_nxt  = '0;
    end else if (op.apply) begin
      case (op.cmd)
        CMD_LOCK, CMD_REQUEST: begin
          free_nxt = sat_sub(free_r, op.n);
          used_nxt = sat_add(used_r, op.n);
        end
        CMD_RESERVE: begin
          free_nxt = sat_sub(free_r, op.n);
          rsv_nxt  = sat_add(rsv_r, op.n);
        end
        CMD_FREE: begin
          free_nxt = sat_add(free_r, op.n);
          used_nxt = sat_sub(used_r, op.n);
        end
        CMD_UNRESERVE: begin
          free_nxt = sat_add(free_r, op.n);
          rsv_nxt  = sat_sub(rsv_r, op.n);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= RESET_FREE;
      used_r <= '0;
      rsv_r  <= '0;
    end else begin
      free_r <= free_nxt;
      used_r <= used_nxt;
      rsv_r  <= rsv_nxt;
    end
  end

  assign free_pages     = free_r;
  assign used_pages     = used_r;
  assign reserved_pages = rsv_r;

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_frame_allocator.sv -----
// Each item is prepared, then its bitmap words are walked in turn, each read and then
//   modified and written back on the single bitmap RAM; a request stops at its first free page,
//   and an empty run or an unknown command walks no word. The result is loaded once the walk is done.
// Throughput: one item at a time; the next item is taken the cycle after its result is loaded.
// Reset and every total_pages write clear the bitmap in a pass that zeroes all
//   MAP_WORDS words (1024 by default), during which no item is taken; the counters restart at once.
`default_nettype none

module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // cmd[2:0], page_index[18:3], page_count[35:19], zero pad
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // granted_page[15:0], found[16], free_pages[33:17], used_pages[50:34],
  // reserved_pages[67:51], zero pad
  output logic      [OUT_W-1:0] out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int LW        = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [31:0] MAXP = 32'(MAX_PAGES);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PREP  = 4'd2;
  localparam logic [3:0] ST_PREP2 = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_WR    = 4'd5;
  localparam logic [3:0] ST_FIN   = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;

  function automatic logic [CNT_W-1:0] eff_lim(input logic [CNT_W-1:0] t);
    return (32'(t) > MAXP) ? MAXP[CNT_W-1:0] : t;
  endfunction

  localparam logic [CNT_W-1:0] RESET_FREE = eff_lim(TOTAL_RESET);

  logic [3:0]        st_r, st_nxt;
  logic [CNT_W-1:0]  total_r;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [15:0]       first_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic [AW-1:0]     wcur_r, wcur_nxt;
  logic [AW-1:0]     wfirst_r, wfirst_nxt;
  logic [AW-1:0]     wlast_r, wlast_nxt;
  logic [LW-1:0]     lo_r, lo_nxt;
  logic [LW-1:0]     hi_r, hi_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [15:0]       granted_r, granted_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [CNT_W-1:0]  lim;
  logic              is_req;
  logic              is_set;
  logic              is_run;
  logic [CNT_W-1:0]  run_sum;
  logic [15:0]       start;
  logic [CNT_W-1:0]  last_pg;
  logic [31:0]       wstart32;
  logic [31:0]       wlast32;
  logic [AW+LW-1:0]  gpage;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [LW-1:0]     op_lo;
  logic [LW-1:0]     op_hi;
  logic [WORD_BITS-1:0] op_word;
  logic [N_W-1:0]    op_n;
  logic              op_hit;
  logic [LW-1:0]     op_idx;

  cnt_op_t           cnt_op;
  logic [CNT_W-1:0]  free_pages;
  logic [CNT_W-1:0]  used_pages;
  logic [CNT_W-1:0]  reserved_pages;

  assign lim      = eff_lim(total_r);
  assign is_req   = (cmd_r == CMD_REQUEST);
  assign is_set   = (cmd_r == CMD_LOCK) || (cmd_r == CMD_RESERVE);
  assign is_run   = is_set || (cmd_r == CMD_FREE) || (cmd_r == CMD_UNRESERVE);
  assign run_sum  = CNT_W'(first_r) + count_r;
  assign start    = is_req ? 16'd0 : first_r;
  assign last_pg  = end_r - CNT_W'(1);
  assign wstart32 = 32'(start) >> LW;
  assign wlast32  = 32'(last_pg) >> LW;
  assign gpage    = {wcur_r, op_idx};

  assign in_tready = (st_r == ST_IDLE);

  // The first and last words of the run get partial masks.
  assign op_lo = (wcur_r == wfirst_r) ? lo_r : '0;
  assign op_hi = (wcur_r == wlast_r) ? hi_r : LW'(WORD_BITS - 1);

  bpfa_word_op #(
    .WB (WORD_BITS)
  ) u_word_op (
    .word     (ram_rdata),
    .lo       (op_lo),
    .hi       (op_hi),
    .set      (is_set),
    .find     (is_req),
    .new_word (op_word),
    .n        (op_n),
    .hit      (op_hit),
    .hit_idx  (op_idx)
  );

  // A word is read and written back before the next one is read, so no
  // access to the same entry ever overlaps.
  assign ram_re    = (st_r == ST_RD);
  assign ram_we    = (st_r == ST_CLR) || (st_r == ST_WR);
  assign ram_waddr = (st_r == ST_CLR) ? clr_r : wcur_r;
  assign ram_wdata = (st_r == ST_CLR) ? '0 : op_word;

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (wcur_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_op.init      = cfg_we;
    cnt_op.init_free = eff_lim(cfg_wdata);
    cnt_op.apply     = (st_r == ST_RD) || (st_r == ST_FIN);
    cnt_op.cmd       = cmd_r;
    cnt_op.n         = n_r;
  end

  bpfa_counters #(
    .RESET_FREE (RESET_FREE)
  ) u_counters (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (cnt_op),
    .free_pages     (free_pages),
    .used_pages     (used_pages),
    .reserved_pages (reserved_pages)
  );

  always_comb begin
    st_nxt      = st_r;
    clr_nxt     = clr_r;
    end_nxt     = end_r;
    wcur_nxt    = wcur_r;
    wfirst_nxt  = wfirst_r;
    wlast_nxt   = wlast_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    n_nxt       = n_r;
    granted_nxt = granted_r;
    found_nxt   = found_r;
    case (st_r)
      ST_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        n_nxt       = '0;
        granted_nxt = '0;
        found_nxt   = 1'b0;
        if (in_tvalid) begin
          st_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (is_req) begin
          end_nxt = lim;
          st_nxt  = ST_PREP2;
        end else if (is_run) begin
          end_nxt = (run_sum < lim) ? run_sum : lim;
          st_nxt  = ST_PREP2;
        end else begin
          st_nxt = ST_FIN;
        end
      end
      ST_PREP2: begin
        if (end_r <= CNT_W'(start)) begin
          st_nxt = ST_FIN;
        end else begin
          wcur_nxt   = wstart32[AW-1:0];
          wfirst_nxt = wstart32[AW-1:0];
          wlast_nxt  = wlast32[AW-1:0];
          lo_nxt     = start[LW-1:0];
          hi_nxt     = last_pg[LW-1:0];
          st_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_WR;
      end
      ST_WR: begin
        n_nxt = op_n;
        if (is_req && op_hit) begin
          granted_nxt = 16'(gpage);
          found_nxt   = 1'b1;
          st_nxt      = ST_FIN;
        end else if (wcur_r == wlast_r) begin
          st_nxt = ST_FIN;
        end else begin
          wcur_nxt = wcur_r + AW'(1);
          st_nxt   = ST_RD;
        end
      end
      ST_FIN: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      st_nxt  = ST_CLR;
      clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLR;
      clr_r   <= '0;
      total_r <= TOTAL_RESET;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tdata[2:0];
      first_r <= in_tdata[18:3];
      count_r <= in_tdata[35:19];
    end
    end_r     <= end_nxt;
    wcur_r    <= wcur_nxt;
    wfirst_r  <= wfirst_nxt;
    wlast_r   <= wlast_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    n_r       <= n_nxt;
    granted_r <= granted_nxt;
    found_r   <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((st_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_data_r <= OUT_W'({reserved_pages, used_pages, free_pages, found_r, granted_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/bpfa_chk.sv -----
// Port-level assertions for the bitmap page frame allocator, bound to the top level.
`default_nettype none

module bpfa_chk
  import bpfa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             cfg_we
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only a successful request carries a nonzero page.
  a_grant_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("granted page without found flag");

  // Reset starts the clearing pass, which takes no item.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken right after reset");

  // A total_pages write restarts the clearing pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("item taken right after reconfiguration");

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule

bind bitmap_page_frame_allocator bpfa_chk u_bpfa_chk (.*);

`default_nettype wire
